// ----- hw/rtl/symbol_frequency_sort_macros.svh -----
// Assertion macros for the symbol frequency sort block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SYMBOL_FREQUENCY_SORT_MACROS_SVH
`define SYMBOL_FREQUENCY_SORT_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define SFS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SFS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define SFS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hw/rtl/sfs_pkg.sv -----
// Shared constants, types and codes of the symbol frequency sort block.
// No dependencies.
package sfs_pkg;

  localparam int MAX_SYMBOLS = 256;
  localparam int COUNT_WIDTH = 16;
  localparam int SYM_W       = $clog2(MAX_SYMBOLS);
  localparam int DIST_W      = $clog2(MAX_SYMBOLS + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [SYM_W-1:0]       LAST_SYM  = SYM_W'(MAX_SYMBOLS - 1);

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_WB,
    ST_SORT_LOAD,
    ST_SORT_PIVOT,
    ST_SORT_SWEEP,
    ST_RD_RANK,
    ST_RD_ORD,
    ST_RD_CNT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                   rd_en;
    logic [SYM_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [SYM_W-1:0]       wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic                   clear;
  } cnt_req_t;

endpackage

// ----- hw/rtl/sfs_in_if.sv -----
// Request channel of the symbol frequency sort block.
// Carries valid, ready and the request fields; no dependencies.
interface sfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] symbol;
  logic [7:0] rank;

  modport source (output valid, func, symbol, rank, input ready);
  modport sink   (input valid, func, symbol, rank, output ready);
endinterface

// ----- hw/rtl/sfs_out_if.sv -----
// Result channel of the symbol frequency sort block.
// Carries valid, ready and the result fields; no dependencies.
interface sfs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  entry_symbol;
  logic [15:0] entry_count;
  logic        entry_valid;
  logic [8:0]  distinct_total;

  modport source (output valid, entry_symbol, entry_count, entry_valid, distinct_total,
                  input ready);
  modport sink   (input valid, entry_symbol, entry_count, entry_valid, distinct_total,
                  output ready);
endinterface

// ----- hw/rtl/sfs_count_store.sv -----
// Symbol-indexed count memory with per-entry valid bits and registered read.
// Depends on sfs_pkg for sizes and the request struct.
module sfs_count_store (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sfs_pkg::cnt_req_t                  req_i,
  output logic [sfs_pkg::COUNT_WIDTH-1:0]    rdata_o
);

  logic [sfs_pkg::COUNT_WIDTH-1:0] mem_q [sfs_pkg::MAX_SYMBOLS];
  logic [sfs_pkg::MAX_SYMBOLS-1:0] vld_q;
  logic [sfs_pkg::COUNT_WIDTH-1:0] rdata_q;
  logic                            rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clear) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
      rvld_q  <= vld_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- hw/rtl/symbol_frequency_sort.sv -----
// Top level of the symbol frequency sort block: control, rank memory, output register.
// Depends on sfs_pkg, sfs_in_if, sfs_out_if, sfs_count_store and the assertion macros.
//
//   channel  dir  modport        fields
//   req_i    in   sfs_in_if      func, symbol, rank
//   rsp_o    out  sfs_out_if     entry_symbol, entry_count, entry_valid, distinct_total
//
// Add requests do one count memory read, then one write back; clear and no-op go to ST_FIN.
// A read on a fresh order does a rank memory read, then a count memory read.
// A stale order is rebuilt first by the rank sweep: load and pivot states per symbol,
// plus a sweep over all MAX_SYMBOLS counts per nonzero symbol, one count read a cycle.
// Reset clears the count valid bits at once; no clearing pass. A stalled result
// holds in the output register and blocks the next result, not the next request.
`include "symbol_frequency_sort_macros.svh"

module symbol_frequency_sort (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfs_in_if.sink     req_i,
  sfs_out_if.source  rsp_o
);

  sfs_pkg::state_e                  state_q, state_d;
  logic [1:0]                       func_q;
  logic [7:0]                       sym_q;
  logic [7:0]                       rank_q;
  logic [sfs_pkg::DIST_W-1:0]       distinct_q, distinct_d;
  logic                             stale_q, stale_d;
  logic [sfs_pkg::SYM_W-1:0]        s_q, s_d;
  logic [sfs_pkg::SYM_W-1:0]        t_q, t_d;
  logic [sfs_pkg::SYM_W-1:0]        acc_q, acc_d;
  logic [sfs_pkg::SYM_W-1:0]        acc_nx;
  logic [sfs_pkg::COUNT_WIDTH-1:0]  piv_q, piv_d;
  logic [sfs_pkg::SYM_W-1:0]        osym_q, osym_d;

  logic                             ovld_q, ovld_d;
  logic [7:0]                       o_sym_q, o_sym_d;
  logic [15:0]                      o_cnt_q, o_cnt_d;
  logic                             o_hit_q, o_hit_d;
  logic [8:0]                       o_dist_q, o_dist_d;

  logic [sfs_pkg::SYM_W-1:0]        ro_mem_q [sfs_pkg::MAX_SYMBOLS];
  logic                             ro_we, ro_re;
  logic [sfs_pkg::SYM_W-1:0]        ro_waddr, ro_wdata, ro_raddr;
  logic [sfs_pkg::SYM_W-1:0]        ro_rdata_q;

  sfs_pkg::cnt_req_t                cnt_req;
  logic [sfs_pkg::COUNT_WIDTH-1:0]  cnt_rdata;

  logic accept, out_free, in_range, less;

  function automatic logic [15:0] sat16(input logic [sfs_pkg::COUNT_WIDTH-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  sfs_count_store u_count_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cnt_req),
    .rdata_o (cnt_rdata)
  );

  assign req_i.ready = (state_q == sfs_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !ovld_q || rsp_o.ready;
  assign in_range    = (9'(sym_q) < 9'(sfs_pkg::MAX_SYMBOLS));
  assign less        = (cnt_rdata != '0) &&
                       ((cnt_rdata < piv_q) || ((cnt_rdata == piv_q) && (t_q < s_q)));
  assign acc_nx      = acc_q + sfs_pkg::SYM_W'(less);

  always_comb begin
    state_d    = state_q;
    distinct_d = distinct_q;
    stale_d    = stale_q;
    s_d        = s_q;
    t_d        = t_q;
    acc_d      = acc_q;
    piv_d      = piv_q;
    osym_d     = osym_q;
    ovld_d     = ovld_q && !rsp_o.ready;
    o_sym_d    = o_sym_q;
    o_cnt_d    = o_cnt_q;
    o_hit_d    = o_hit_q;
    o_dist_d   = o_dist_q;
    cnt_req    = '0;
    ro_we      = 1'b0;
    ro_waddr   = '0;
    ro_wdata   = '0;
    ro_re      = 1'b0;
    ro_raddr   = '0;

    case (state_q)
      sfs_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.func)
            sfs_pkg::FUNC_ADD: begin
              cnt_req.rd_en   = 1'b1;
              cnt_req.rd_addr = req_i.symbol[sfs_pkg::SYM_W-1:0];
              state_d         = sfs_pkg::ST_ADD_WB;
            end
            sfs_pkg::FUNC_READ: begin
              s_d     = '0;
              state_d = stale_q ? sfs_pkg::ST_SORT_LOAD : sfs_pkg::ST_RD_RANK;
            end
            default: begin
              state_d = sfs_pkg::ST_FIN;
            end
          endcase
        end
      end

      sfs_pkg::ST_ADD_WB: begin
        if (out_free) begin
          if (in_range) begin
            if (cnt_rdata == '0) begin
              distinct_d = distinct_q + sfs_pkg::DIST_W'(1);
            end
            if (cnt_rdata != sfs_pkg::COUNT_MAX) begin
              cnt_req.wr_en   = 1'b1;
              cnt_req.wr_addr = sym_q[sfs_pkg::SYM_W-1:0];
              cnt_req.wr_data = cnt_rdata + sfs_pkg::COUNT_WIDTH'(1);
            end
            stale_d = 1'b1;
          end
          ovld_d   = 1'b1;
          o_sym_d  = '0;
          o_cnt_d  = '0;
          o_hit_d  = 1'b0;
          o_dist_d = 9'(distinct_d);
          state_d  = sfs_pkg::ST_IDLE;
        end
      end

      sfs_pkg::ST_SORT_LOAD: begin
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = s_q;
        state_d         = sfs_pkg::ST_SORT_PIVOT;
      end

      sfs_pkg::ST_SORT_PIVOT: begin
        piv_d = cnt_rdata;
        if (cnt_rdata == '0) begin
          if (s_q == sfs_pkg::LAST_SYM) begin
            stale_d = 1'b0;
            state_d = sfs_pkg::ST_RD_RANK;
          end else begin
            s_d     = s_q + sfs_pkg::SYM_W'(1);
            state_d = sfs_pkg::ST_SORT_LOAD;
          end
        end else begin
          cnt_req.rd_en   = 1'b1;
          cnt_req.rd_addr = '0;
          t_d             = '0;
          acc_d           = '0;
          state_d         = sfs_pkg::ST_SORT_SWEEP;
        end
      end

      sfs_pkg::ST_SORT_SWEEP: begin
        if (t_q == sfs_pkg::LAST_SYM) begin
          ro_we    = 1'b1;
          ro_waddr = acc_nx;
          ro_wdata = s_q;
          if (s_q == sfs_pkg::LAST_SYM) begin
            stale_d = 1'b0;
            state_d = sfs_pkg::ST_RD_RANK;
          end else begin
            s_d     = s_q + sfs_pkg::SYM_W'(1);
            state_d = sfs_pkg::ST_SORT_LOAD;
          end
        end else begin
          cnt_req.rd_en   = 1'b1;
          cnt_req.rd_addr = t_q + sfs_pkg::SYM_W'(1);
          t_d             = t_q + sfs_pkg::SYM_W'(1);
          acc_d           = acc_nx;
        end
      end

      sfs_pkg::ST_RD_RANK: begin
        if (9'(rank_q) < 9'(distinct_q)) begin
          ro_re    = 1'b1;
          ro_raddr = rank_q[sfs_pkg::SYM_W-1:0];
          state_d  = sfs_pkg::ST_RD_ORD;
        end else begin
          state_d = sfs_pkg::ST_FIN;
        end
      end

      sfs_pkg::ST_RD_ORD: begin
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = ro_rdata_q;
        osym_d          = ro_rdata_q;
        state_d         = sfs_pkg::ST_RD_CNT;
      end

      sfs_pkg::ST_RD_CNT: begin
        if (out_free) begin
          ovld_d   = 1'b1;
          o_sym_d  = 8'(osym_q);
          o_cnt_d  = sat16(cnt_rdata);
          o_hit_d  = 1'b1;
          o_dist_d = 9'(distinct_q);
          state_d  = sfs_pkg::ST_IDLE;
        end
      end

      sfs_pkg::ST_FIN: begin
        if (out_free) begin
          if (func_q == sfs_pkg::FUNC_CLEAR) begin
            cnt_req.clear = 1'b1;
            distinct_d    = '0;
            stale_d       = 1'b0;
          end
          ovld_d   = 1'b1;
          o_sym_d  = '0;
          o_cnt_d  = '0;
          o_hit_d  = 1'b0;
          o_dist_d = 9'(distinct_d);
          state_d  = sfs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sfs_pkg::ST_IDLE;
      distinct_q <= '0;
      stale_q    <= 1'b0;
      ovld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      distinct_q <= distinct_d;
      stale_q    <= stale_d;
      ovld_q     <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      sym_q  <= req_i.symbol;
      rank_q <= req_i.rank;
    end
    s_q      <= s_d;
    t_q      <= t_d;
    acc_q    <= acc_d;
    piv_q    <= piv_d;
    osym_q   <= osym_d;
    o_sym_q  <= o_sym_d;
    o_cnt_q  <= o_cnt_d;
    o_hit_q  <= o_hit_d;
    o_dist_q <= o_dist_d;
  end

  always_ff @(posedge clk_i) begin
    if (ro_we) begin
      ro_mem_q[ro_waddr] <= ro_wdata;
    end
    if (ro_re) begin
      ro_rdata_q <= ro_mem_q[ro_raddr];
    end
  end

  assign rsp_o.valid          = ovld_q;
  assign rsp_o.entry_symbol   = o_sym_q;
  assign rsp_o.entry_count    = o_cnt_q;
  assign rsp_o.entry_valid    = o_hit_q;
  assign rsp_o.distinct_total = o_dist_q;

  `SFS_ASSERT_NEXT(a_add_to_wb, accept && (req_i.func == sfs_pkg::FUNC_ADD), state_q == sfs_pkg::ST_ADD_WB, "add request did not reach write back")
  `SFS_ASSERT_IMPL(a_rank_in_range, ro_we, 9'(ro_waddr) < 9'(distinct_q), "rank write beyond distinct total")
  `SFS_ASSERT_IMPL(a_hit_nonzero, rsp_o.valid && rsp_o.entry_valid, rsp_o.entry_count != 16'd0, "valid entry with zero count")
  `SFS_ASSERT_ALWAYS(a_distinct_max, 9'(distinct_q) <= 9'(sfs_pkg::MAX_SYMBOLS), "distinct total beyond symbol range")

endmodule

// ----- tb/tb_symbol_frequency_sort.sv -----
// Self-checking testbench for symbol_frequency_sort: queued requests, a clocked driver and
// monitor, and a histogram predictor that ranks symbols by count, then by symbol value.
// Depends on sfs_pkg, sfs_in_if, sfs_out_if and the symbol_frequency_sort RTL.
module tb_symbol_frequency_sort;

  localparam logic [1:0] FUNC_NOP  = 2'd3;
  localparam int         HOLD_SPAN = 400;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] symbol;
    logic [7:0] rank;
  } sfs_req_t;

  typedef struct packed {
    logic [7:0]  entry_symbol;
    logic [15:0] entry_count;
    logic        entry_valid;
    logic [8:0]  distinct_total;
  } sfs_entry_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       req_valid    = 1'b0;
  logic [1:0] req_func     = sfs_pkg::FUNC_ADD;
  logic [7:0] req_symbol   = '0;
  logic [7:0] req_rank     = '0;
  logic       rsp_ready    = 1'b0;
  logic       hold_rsp     = 1'b0;
  logic       squeeze_go   = 1'b0;

  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         queued_total  = 0;
  int         error_count   = 0;

  sfs_req_t   requests_pending[$];
  sfs_entry_t entries_due[$];
  sfs_req_t   next_req;
  sfs_entry_t got_entry;
  sfs_entry_t want_entry;

  int unsigned sym_tally[sfs_pkg::MAX_SYMBOLS];
  logic [7:0]  ranked_syms[sfs_pkg::MAX_SYMBOLS];
  int unsigned tally_distinct = 0;
  bit          ranking_stale  = 1'b0;

  sfs_in_if  req_if ();
  sfs_out_if rsp_if ();

  assign req_if.valid  = req_valid;
  assign req_if.func   = req_func;
  assign req_if.symbol = req_symbol;
  assign req_if.rank   = req_rank;
  assign rsp_if.ready  = rsp_ready;

  symbol_frequency_sort i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #200_000_000;
    $display("symbol_frequency_sort test failed");
    $finish;
  end

  // Hold off the result channel while the sender keeps offering requests.
  initial begin
    wait (squeeze_go);
    @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (HOLD_SPAN) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  function automatic void rank_symbols();
    int unsigned pos;
    for (int s = 0; s < sfs_pkg::MAX_SYMBOLS; s++) begin
      if (sym_tally[s] != 0) begin
        pos = 0;
        for (int t = 0; t < sfs_pkg::MAX_SYMBOLS; t++) begin
          if (sym_tally[t] != 0 && (sym_tally[t] < sym_tally[s] ||
              (sym_tally[t] == sym_tally[s] && t < s))) begin
            pos++;
          end
        end
        ranked_syms[pos] = 8'(s);
      end
    end
    ranking_stale = 1'b0;
  endfunction

  function automatic sfs_entry_t tally_request(sfs_req_t r);
    sfs_entry_t e;
    e = '0;
    case (r.func)
      sfs_pkg::FUNC_ADD: begin
        if (sym_tally[r.symbol] == 0) tally_distinct++;
        if (sym_tally[r.symbol] < int'(sfs_pkg::COUNT_MAX)) sym_tally[r.symbol]++;
        ranking_stale = 1'b1;
      end
      sfs_pkg::FUNC_READ: begin
        if (ranking_stale) rank_symbols();
        if (r.rank < tally_distinct) begin
          e.entry_symbol = ranked_syms[r.rank];
          e.entry_count  = 16'(sym_tally[ranked_syms[r.rank]]);
          e.entry_valid  = 1'b1;
        end
      end
      sfs_pkg::FUNC_CLEAR: begin
        foreach (sym_tally[s]) sym_tally[s] = 0;
        tally_distinct = 0;
        ranking_stale  = 1'b0;
      end
      default: ;
    endcase
    e.distinct_total = 9'(tally_distinct);
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid  <= 1'b0;
      req_func   <= sfs_pkg::FUNC_ADD;
      req_symbol <= '0;
      req_rank   <= '0;
    end else begin
      if (req_valid && req_if.ready) begin
        entries_due.push_back(tally_request('{req_func, req_symbol, req_rank}));
      end
      if (!req_valid || req_if.ready) begin
        if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req   = requests_pending.pop_front();
          req_valid  <= 1'b1;
          req_func   <= next_req.func;
          req_symbol <= next_req.symbol;
          req_rank   <= next_req.rank;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        got_entry = '{rsp_if.entry_symbol, rsp_if.entry_count, rsp_if.entry_valid,
                      rsp_if.distinct_total};
        if (entries_due.size() == 0) begin
          $display("%0t: unexpected result sym %0h cnt %0d valid %0b total %0d", $time,
                   got_entry.entry_symbol, got_entry.entry_count, got_entry.entry_valid,
                   got_entry.distinct_total);
          error_count++;
        end else begin
          want_entry = entries_due.pop_front();
          if (got_entry !== want_entry) begin
            $display("%0t: expected %0h/%0d/%0b/%0d, got %0h/%0d/%0b/%0d",
                     $time, want_entry.entry_symbol, want_entry.entry_count,
                     want_entry.entry_valid, want_entry.distinct_total,
                     got_entry.entry_symbol, got_entry.entry_count, got_entry.entry_valid,
                     got_entry.distinct_total);
            error_count++;
          end
        end
      end
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_req(logic [1:0] func, logic [7:0] symbol, logic [7:0] rank);
    requests_pending.push_back('{func, symbol, rank});
    queued_total++;
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (requests_pending.size() != 0 || req_valid || entries_due.size() != 0);
  endtask

  task automatic queue_directed();
    push_req(sfs_pkg::FUNC_READ, 8'h00, 8'h00);
    push_req(FUNC_NOP, 8'hFF, 8'hFF);
    push_req(sfs_pkg::FUNC_ADD, 8'h00, 8'hFF);
    push_req(sfs_pkg::FUNC_ADD, 8'hFF, 8'h00);
    push_req(sfs_pkg::FUNC_ADD, 8'hFF, 8'h00);
    push_req(sfs_pkg::FUNC_ADD, 8'h80, 8'h00);
    push_req(sfs_pkg::FUNC_ADD, 8'h7F, 8'h00);
    for (int r = 0; r < 5; r++) push_req(sfs_pkg::FUNC_READ, 8'hFF, 8'(r));
    push_req(sfs_pkg::FUNC_READ, 8'h00, 8'hFF);
    push_req(sfs_pkg::FUNC_ADD, 8'h00, 8'h00);
    push_req(sfs_pkg::FUNC_ADD, 8'h00, 8'h00);
    push_req(sfs_pkg::FUNC_READ, 8'h00, 8'h00);
    push_req(sfs_pkg::FUNC_READ, 8'h00, 8'h03);
    push_req(FUNC_NOP, 8'h00, 8'h00);
    push_req(sfs_pkg::FUNC_CLEAR, 8'hFF, 8'hFF);
    push_req(sfs_pkg::FUNC_READ, 8'h00, 8'h00);
    push_req(sfs_pkg::FUNC_ADD, 8'h55, 8'hAA);
    push_req(sfs_pkg::FUNC_READ, 8'hAA, 8'h00);
    push_req(sfs_pkg::FUNC_CLEAR, 8'h00, 8'h00);
  endtask

  // Build one heavy symbol next to a light one, read ranks 0 to 2, then clear.
  task automatic queue_heavy_symbol();
    for (int i = 0; i < 24; i++) push_req(sfs_pkg::FUNC_ADD, 8'hA5, 8'h00);
    push_req(sfs_pkg::FUNC_ADD, 8'h3C, 8'h00);
    push_req(sfs_pkg::FUNC_ADD, 8'h3C, 8'h00);
    for (int r = 0; r < 3; r++) push_req(sfs_pkg::FUNC_READ, 8'h00, 8'(r));
    push_req(sfs_pkg::FUNC_CLEAR, 8'h00, 8'h00);
  endtask

  task automatic queue_full_alphabet();
    logic [7:0] base;
    base = 8'($urandom_range(255));
    for (int i = 0; i < sfs_pkg::MAX_SYMBOLS; i++) begin
      push_req(sfs_pkg::FUNC_ADD, base + 8'(i), 8'($urandom_range(255)));
    end
    for (int i = 0; i < 20; i++) push_req(sfs_pkg::FUNC_ADD, 8'($urandom_range(255)), 8'h00);
    push_req(sfs_pkg::FUNC_READ, 8'h00, 8'h00);
    push_req(sfs_pkg::FUNC_READ, 8'h00, 8'hFF);
    push_req(sfs_pkg::FUNC_READ, 8'h00, 8'h80);
    push_req(sfs_pkg::FUNC_READ, 8'h00, 8'($urandom_range(255)));
    push_req(sfs_pkg::FUNC_CLEAR, 8'h00, 8'h00);
  endtask

  task automatic queue_random_sequence();
    int         kind;
    int         alpha_n;
    logic [7:0] alphabet[12];
    kind = $urandom_range(99);
    if (kind < 75) begin
      alpha_n = $urandom_range(1, 12);
      for (int i = 0; i < alpha_n; i++) alphabet[i] = 8'($urandom_range(255));
      repeat ($urandom_range(1, 16)) begin
        push_req(sfs_pkg::FUNC_ADD, alphabet[$urandom_range(alpha_n - 1)],
                 8'($urandom_range(255)));
      end
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(4) == 0) push_req(sfs_pkg::FUNC_READ, 8'($urandom_range(255)),
                                             8'($urandom_range(255)));
        else push_req(sfs_pkg::FUNC_READ, 8'($urandom_range(255)),
                      8'($urandom_range(alpha_n + 1)));
      end
      if ($urandom_range(3) == 0) push_req(sfs_pkg::FUNC_CLEAR, 8'($urandom_range(255)),
                                           8'($urandom_range(255)));
    end else if (kind < 83) begin
      push_req(sfs_pkg::FUNC_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end else if (kind < 90) begin
      push_req(FUNC_NOP, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end else begin
      push_req(sfs_pkg::FUNC_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  task automatic queue_random(int span);
    int start;
    start = queued_total;
    while (queued_total - start < span) queue_random_sequence();
  endtask

  initial begin
    wait (rst_ni);
    queue_directed();
    queue_heavy_symbol();
    wait_quiet();

    squeeze_go = 1'b1;
    for (int i = 0; i < 40; i++) begin
      push_req($urandom_range(1) ? sfs_pkg::FUNC_ADD : FUNC_NOP, 8'($urandom_range(255)),
               8'($urandom_range(255)));
    end
    queue_random(80);
    wait_quiet();

    send_idle_pct = 82;
    queue_random(80);
    wait_quiet();

    send_idle_pct = 0;
    stall_pct     = 82;
    queue_random(80);
    wait_quiet();

    send_idle_pct = 22;
    stall_pct     = 22;
    queue_full_alphabet();
    queue_random(80);
    wait_quiet();

    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("symbol_frequency_sort test passed");
    end else begin
      $display("symbol_frequency_sort test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_in_if.sv
hw/rtl/sfs_out_if.sv
hw/rtl/sfs_count_store.sv
hw/rtl/symbol_frequency_sort.sv
tb/tb_symbol_frequency_sort.sv
